// ===== rtl/deq_pkg.sv =====
// shared constants and types for the double-ended queue
package deq_pkg;

  localparam int unsigned OUT_BITS      = 32;
  localparam int unsigned MODE_BITS     = 3;
  localparam int unsigned DEF_CAPACITY  = 16;
  localparam int unsigned DEF_WORD_BITS = 32;

  localparam logic [OUT_BITS-1:0] EMPTY_VALUE = '1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_QUERY      = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

endpackage

// ===== rtl/double_ended_queue.sv =====
// bounded double-ended queue of signed words kept in a ring memory
//
// Each accepted word on the input channel is one operation (push back, push front,
// pop front, pop back or query; unused mode codes act as a query) and gives exactly
// one result word with the front and rear entries (-1 when empty), the empty and full
// flags and a flag for a push refused because the queue was full. Pushes and queries
// complete in the idle state; a pop that leaves the queue non-empty also visits
// the read state, stalling the input, as its new front or rear entry is fetched from
// the single-port-read ring memory, whose read data is registered. The front and rear
// entries are held in registers, so only pops touch the memory read port. The ring
// memory needs no clearing after reset: an entry is read only after a push wrote it.
module double_ended_queue #(
  parameter int unsigned CAPACITY  = deq_pkg::DEF_CAPACITY,
  parameter int unsigned WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [deq_pkg::MODE_BITS-1:0]      mode_i,
  input  logic signed [deq_pkg::OUT_BITS-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [deq_pkg::OUT_BITS-1:0] front_value_o,
  output logic signed [deq_pkg::OUT_BITS-1:0] rear_value_o,
  output logic                               is_empty_o,
  output logic                               is_full_o,
  output logic                               push_dropped_o
);
  import deq_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

  logic [WORD_BITS-1:0] mem [CAPACITY];

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    head_q, head_d;
  logic [ADDR_W-1:0]    rear_q, rear_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [WORD_BITS-1:0] front_word_q, front_word_d;
  logic [WORD_BITS-1:0] rear_word_q, rear_word_d;
  logic                 out_valid_q, out_valid_d;
  logic                 dropped_q, dropped_d;
  logic                 read_front_q, read_front_d;
  logic [WORD_BITS-1:0] rd_data_q;

  logic                 in_accept;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] in_word;
  logic [OUT_BITS-1:0]  front_ext;
  logic [OUT_BITS-1:0]  rear_ext;
  logic [ADDR_W-1:0]    head_inc, head_dec, rear_inc, rear_dec;
  logic                 is_empty, is_full;
  mode_e                mode;

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == FULL_CNT);

  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + ADDR_W'(1);
  assign head_dec = (head_q == '0) ? LAST_SLOT : head_q - ADDR_W'(1);
  assign rear_inc = (rear_q == LAST_SLOT) ? '0 : rear_q + ADDR_W'(1);
  assign rear_dec = (rear_q == '0) ? LAST_SLOT : rear_q - ADDR_W'(1);

  generate
    if (WORD_BITS >= OUT_BITS) begin : g_wide
      assign front_ext = front_word_q[OUT_BITS-1:0];
      assign rear_ext  = rear_word_q[OUT_BITS-1:0];
      if (WORD_BITS > OUT_BITS) begin : g_pad
        assign in_word = {{(WORD_BITS-OUT_BITS){1'b0}}, value_i};
      end else begin : g_same
        assign in_word = value_i;
      end
    end else begin : g_narrow
      assign front_ext = {{(OUT_BITS-WORD_BITS){front_word_q[WORD_BITS-1]}}, front_word_q};
      assign rear_ext  = {{(OUT_BITS-WORD_BITS){rear_word_q[WORD_BITS-1]}}, rear_word_q};
      assign in_word   = value_i[WORD_BITS-1:0];
    end
  endgenerate

  assign in_stall_o     = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept      = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign front_value_o  = is_empty ? EMPTY_VALUE : front_ext;
  assign rear_value_o   = is_empty ? EMPTY_VALUE : rear_ext;
  assign is_empty_o     = is_empty;
  assign is_full_o      = is_full;
  assign push_dropped_o = dropped_q;

  always_comb begin
    mode         = mode_e'(mode_i);
    state_d      = state_q;
    head_d       = head_q;
    rear_d       = rear_q;
    count_d      = count_q;
    front_word_d = front_word_q;
    rear_word_d  = rear_word_q;
    dropped_d    = dropped_q;
    read_front_d = read_front_q;
    out_valid_d  = out_valid_q && out_stall_i;
    wr_en        = 1'b0;
    wr_addr      = rear_inc;
    rd_en        = 1'b0;
    rd_addr      = head_inc;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          dropped_d   = 1'b0;
          out_valid_d = 1'b1;
          case (mode)
            MODE_PUSH_BACK: begin
              if (is_full) begin
                dropped_d = 1'b1;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = rear_inc;
                rear_d      = rear_inc;
                count_d     = count_q + ONE_CNT;
                rear_word_d = in_word;
                if (is_empty) begin
                  front_word_d = in_word;
                end
              end
            end
            MODE_PUSH_FRONT: begin
              if (is_full) begin
                dropped_d = 1'b1;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = head_dec;
                head_d       = head_dec;
                count_d      = count_q + ONE_CNT;
                front_word_d = in_word;
                if (is_empty) begin
                  rear_word_d = in_word;
                end
              end
            end
            MODE_POP_FRONT: begin
              if (!is_empty) begin
                head_d  = head_inc;
                count_d = count_q - ONE_CNT;
                if (count_q != ONE_CNT) begin
                  rd_en        = 1'b1;
                  rd_addr      = head_inc;
                  read_front_d = 1'b1;
                  out_valid_d  = 1'b0;
                  state_d      = ST_READ;
                end
              end
            end
            MODE_POP_BACK: begin
              if (!is_empty) begin
                rear_d  = rear_dec;
                count_d = count_q - ONE_CNT;
                if (count_q != ONE_CNT) begin
                  rd_en        = 1'b1;
                  rd_addr      = rear_dec;
                  read_front_d = 1'b0;
                  out_valid_d  = 1'b0;
                  state_d      = ST_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (read_front_q) begin
          front_word_d = rd_data_q;
        end else begin
          rear_word_d = rd_data_q;
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_word;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      rear_q       <= LAST_SLOT;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      dropped_q    <= 1'b0;
      read_front_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      rear_q       <= rear_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      dropped_q    <= dropped_d;
      read_front_q <= read_front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_word_q <= front_word_d;
    rear_word_q  <= rear_word_d;
  end

endmodule
